>>> rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared constants, operation and status codes, and the state machine type.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned DefBuckets = 64;
  localparam int unsigned DefNodes   = 256;
  localparam int unsigned KeyW       = 31;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CfgW       = 7;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpSearch = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_HEAD_WAIT,
    S_NODE,
    S_NODE_WAIT,
    S_FREE_WAIT,
    S_UNLINK,
    S_RESULT
  } state_e;

endpackage

>>> rtl/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Key-value table with separate chaining over a node pool held in memories.
// ----------------------------------------------------------------------------
// The engine takes one request at a time. After reset it runs a clearing pass
// that empties the bucket heads and loads free stack entry i with node i. No
// request is accepted during the pass, but configuration writes are taken. A
// request first reduces the key modulo the configured bucket count with a
// restoring shift-subtract unit. That unit produces one quotient bit per cycle.
// The request then reads the bucket head. What follows depends on the op:
//   - an insert into a full pool and an unknown op go straight to the result;
//   - a successful insert takes a node from the free stack and links it in
//     at the head of its bucket's chain;
//   - search and delete walk the chain, reading each node and then comparing
//     its key, since the node store read is registered;
//   - a search hit returns the node's value, a miss reports not found, and a
//     delete hit unlinks the node and returns it to the free stack.
// Each finished transaction moves into an output register, and the next
// request is accepted while that register waits. A new result that finds the
// register still occupied holds the engine in its result state until the
// receiver takes the old one.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned NODES   = DefNodes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[1:0], key[32:2], value[64:33], zero fill to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], found_value[33:2], zero fill to 40 bits
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned MW = $clog2(BUCKETS + 1);
  localparam int unsigned CN = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int unsigned CW = $clog2(CN);
  localparam logic [LW-1:0] Null = LW'(NODES);

  // memories
  logic [LW-1:0]   head_mem [BUCKETS];
  logic [KeyW-1:0] key_mem  [NODES];
  logic [ValW-1:0] val_mem  [NODES];
  logic [LW-1:0]   link_mem [NODES];
  logic [NW-1:0]   free_mem [NODES];

  state_e state_q, state_d;

  logic [CfgW-1:0] bcnt_q;
  logic [1:0]      op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [KeyW-1:0] rem_q, rem_d;
  logic [4:0]      bit_q;
  logic [MW-1:0]   div_q;
  logic [BW-1:0]   bkt_q;
  logic [CW-1:0]   clr_q;
  logic [LW-1:0]   cur_q, prev_q;
  logic [LW-1:0]   steps_q;
  logic [LW-1:0]   fcnt_q;
  logic [1:0]      status_q;
  logic [ValW-1:0] found_q;
  logic            ovalid_q;
  logic [1:0]      res_status_q;
  logic [ValW-1:0] res_found_q;

  // registered read data
  logic [LW-1:0]   head_rd_q;
  logic [KeyW-1:0] key_rd_q;
  logic [ValW-1:0] val_rd_q;
  logic [LW-1:0]   link_rd_q;
  logic [NW-1:0]   free_rd_q;

  logic            in_fire;
  logic            res_load;
  logic [KeyW:0]   trial;
  logic [MW-1:0]   div_eff;
  logic [NW-1:0]   free_ra;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // the output register can take a new result when empty or being drained
  assign res_load      = !ovalid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, res_found_q, res_status_q};

  // clamp divisor into 1..BUCKETS
  always_comb begin
    if (bcnt_q == '0) begin
      div_eff = MW'(1);
    end else if ({25'd0, bcnt_q} > 32'(BUCKETS)) begin
      div_eff = MW'(BUCKETS);
    end else begin
      div_eff = MW'(bcnt_q);
    end
  end

  // restoring modulo step: shift in next key bit, subtract if possible
  always_comb begin
    trial = {rem_q, key_q[bit_q]};
    if (trial >= (KeyW+1)'(div_q)) begin
      trial = trial - (KeyW+1)'(div_q);
    end
    rem_d = trial[KeyW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (32'(clr_q) == CN - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_d = S_MOD;
      end
      S_MOD: begin
        if (bit_q == '0) state_d = S_HEAD;
      end
      S_HEAD:      state_d = S_HEAD_WAIT;
      S_HEAD_WAIT: begin
        if (op_q == OpInsert) begin
          state_d = (fcnt_q == '0) ? S_RESULT : S_FREE_WAIT;
        end else if (op_q == OpSearch || op_q == OpDelete) begin
          state_d = S_NODE;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_FREE_WAIT: state_d = S_RESULT;
      S_NODE: begin
        if (cur_q >= Null || steps_q >= Null) state_d = S_RESULT;
        else state_d = S_NODE_WAIT;
      end
      S_NODE_WAIT: begin
        if (key_rd_q == key_q) begin
          state_d = (op_q == OpDelete) ? S_UNLINK : S_RESULT;
        end else begin
          state_d = S_NODE;
        end
      end
      S_UNLINK:    state_d = S_RESULT;
      S_RESULT: begin
        if (res_load) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      bcnt_q   <= CfgW'(64);
      clr_q    <= '0;
      fcnt_q   <= Null;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) bcnt_q <= cfg_data_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + CW'(1);
      if (state_q == S_RESULT && res_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (state_q == S_FREE_WAIT) fcnt_q <= fcnt_q - LW'(1);
      if (state_q == S_UNLINK && fcnt_q < Null) fcnt_q <= fcnt_q + LW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q     <= s_axis_tdata[1:0];
        key_q    <= s_axis_tdata[32:2];
        val_q    <= s_axis_tdata[64:33];
        rem_q    <= '0;
        bit_q    <= 5'(KeyW - 1);
        div_q    <= div_eff;
        status_q <= StDone;
        found_q  <= '0;
      end
      S_MOD: begin
        rem_q <= rem_d;
        bit_q <= bit_q - 5'd1;
      end
      S_HEAD: begin
        bkt_q <= rem_q[BW-1:0];
      end
      S_HEAD_WAIT: begin
        cur_q   <= head_rd_q;
        prev_q  <= Null;
        steps_q <= '0;
        if (op_q == OpInsert && fcnt_q == '0) status_q <= StFull;
      end
      S_NODE: begin
        if (cur_q >= Null || steps_q >= Null) status_q <= StNotFound;
      end
      S_NODE_WAIT: begin
        if (key_rd_q == key_q) begin
          if (op_q == OpSearch) found_q <= val_rd_q;
        end else begin
          prev_q  <= cur_q;
          cur_q   <= link_rd_q;
          steps_q <= steps_q + LW'(1);
        end
      end
      S_RESULT: begin
        if (res_load) begin
          res_status_q <= status_q;
          res_found_q  <= found_q;
        end
      end
      default: ;
    endcase
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (32'(clr_q) < BUCKETS) head_mem[clr_q[BW-1:0]] <= Null;
    end else if (state_q == S_FREE_WAIT) begin
      head_mem[bkt_q] <= LW'(free_rd_q);
    end else if (state_q == S_UNLINK && prev_q == Null) begin
      head_mem[bkt_q] <= link_rd_q;
    end
    head_rd_q <= head_mem[rem_q[BW-1:0]];
  end

  // node memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_FREE_WAIT) begin
      key_mem[free_rd_q]  <= key_q;
      val_mem[free_rd_q]  <= val_q;
      link_mem[free_rd_q] <= head_rd_q;
    end else if (state_q == S_UNLINK && prev_q != Null) begin
      link_mem[prev_q[NW-1:0]] <= link_rd_q;
    end
    key_rd_q  <= key_mem[cur_q[NW-1:0]];
    val_rd_q  <= val_mem[cur_q[NW-1:0]];
    link_rd_q <= link_mem[cur_q[NW-1:0]];
  end

  // free stack: loaded with node i at entry i by the clearing pass;
  // the top entry is read continuously
  assign free_ra = NW'(fcnt_q - LW'(1));

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (32'(clr_q) < NODES) free_mem[clr_q[NW-1:0]] <= clr_q[NW-1:0];
    end else if (state_q == S_UNLINK && fcnt_q < Null) begin
      free_mem[fcnt_q[NW-1:0]] <= cur_q[NW-1:0];
    end
    free_rd_q <= free_mem[free_ra];
  end

endmodule

>>> dv/tb_chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// Chained hash table engine testbench
// Streams insert, search, delete and unknown requests through the engine under
// several bucket counts. A table shadow in a small class predicts each
// response, and every response is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cht_pkg::*;

  localparam int unsigned NBkt = DefBuckets;
  localparam int unsigned NNode = DefNodes;
  localparam logic [1:0] OpUnknown = 2'd3;
  localparam int unsigned CycleLimit = 4000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } response_t;

  // Shadow of the table: bucket heads, node pool and free stack.
  class table_shadow;
    int unsigned bucket_sel;
    int unsigned head[NBkt];
    logic [30:0] nkey[NNode];
    logic [31:0] nval[NNode];
    int unsigned nlink[NNode];
    int unsigned free_stk[NNode];
    int unsigned free_cnt;
    response_t pending[$];
    int unsigned failures;
    int unsigned n_checked;
    int unsigned n_full, n_hit, n_miss;

    function new();
      bucket_sel = 64;
      foreach (head[i]) head[i] = NNode;
      foreach (free_stk[i]) free_stk[i] = i;
      free_cnt = NNode;
    endfunction

    function int unsigned walk(int unsigned b, logic [30:0] key, output int unsigned prev);
      int unsigned cur, pv, steps;
      cur = head[b];
      pv = NNode;
      steps = 0;
      prev = NNode;
      while (cur < NNode && steps < NNode) begin
        if (nkey[cur] == key) begin
          prev = pv;
          return cur;
        end
        pv = cur;
        cur = nlink[cur];
        steps++;
      end
      return NNode;
    endfunction

    // Note one accepted request: update the shadow, queue its response.
    function void note_request(logic [1:0] op, logic [30:0] key, logic [31:0] val);
      response_t r;
      int unsigned n, b, node, prev;
      n = bucket_sel == 0 ? 1 : (bucket_sel > NBkt ? NBkt : bucket_sel);
      b = key % n;
      r = '0;
      case (op) inside
        OpInsert: begin
          if (free_cnt == 0) begin
            r.status = StFull;
            n_full++;
          end else begin
            free_cnt--;
            node = free_stk[free_cnt];
            nkey[node] = key;
            nval[node] = val;
            nlink[node] = head[b];
            head[b] = node;
          end
        end
        OpSearch, OpDelete: begin
          node = walk(b, key, prev);
          if (node >= NNode) begin
            r.status = StNotFound;
            n_miss++;
          end else begin
            n_hit++;
            if (op == OpSearch) begin
              r.value = nval[node];
            end else begin
              if (prev < NNode) nlink[prev] = nlink[node];
              else head[b] = nlink[node];
              if (free_cnt < NNode) begin
                free_stk[free_cnt] = node;
                free_cnt++;
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [31:0] value);
      response_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected response: status %0d found_value %0h", status, value);
        failures++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        failures++;
      end
      if (value !== e.value) begin
        $error("found_value: expected %0h, actual %0h", e.value, value);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: op[1:0], key[32:2], value[64:33], zero fill to 72 bits
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: status[1:0], found_value[33:2], zero fill to 40 bits
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  table_shadow shadow = new();
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  logic [30:0] key_pool[24];

  chained_hash_table_engine_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Bound the run; a hang ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every response transaction as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.check_response(m_axis_tdata[1:0], m_axis_tdata[33:2]);
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver backpressure: mostly short stalls, a few long ones, idle-free runs.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // Send one request transaction; optionally idle first.
  task automatic send_request(logic [1:0] op, logic [30:0] key, logic [31:0] val);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, val, key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(op, key, val);
    n_sent++;
  endtask

  // Hold off until every response is back, then let the engine settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [6:0] cnt);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow.bucket_sel = cnt;
  endtask

  function automatic logic [30:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 23)];
    return 31'($urandom() & 32'h7fff_ffff);
  endfunction

  // Random mix; weights in percent for insert and delete, rest search/unknown.
  task automatic random_phase(int unsigned count, int unsigned w_ins, int unsigned w_del);
    int unsigned p;
    logic [1:0] op;
    repeat (count) begin
      p = $urandom_range(0, 99);
      if (p < w_ins) op = OpInsert;
      else if (p < w_ins + w_del) op = OpDelete;
      else if (p < 98) op = OpSearch;
      else op = OpUnknown;
      send_request(op, pick_key(), $urandom());
    end
    drain();
  endtask

  initial begin
    foreach (key_pool[i])
      key_pool[i] = (i < 12) ? 31'(i * 64 + (i % 3)) : 31'($urandom() & 32'h7fff_ffff);
    key_pool[0] = 31'd0;
    key_pool[1] = 31'h7fff_ffff;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, colliding chains, misses, unknown op.
    write_bucket_count(7'd64);
    send_request(OpSearch, 31'd0, 32'h0);
    send_request(OpDelete, 31'h7fff_ffff, 32'h0);
    send_request(OpInsert, 31'd0, 32'h8000_0000);
    send_request(OpInsert, 31'h7fff_ffff, 32'h7fff_ffff);
    send_request(OpSearch, 31'd0, 32'hffff_ffff);
    send_request(OpSearch, 31'h7fff_ffff, 32'h0);
    send_request(OpInsert, 31'd0, 32'hffff_ffff);
    send_request(OpSearch, 31'd0, 32'h0);
    send_request(OpInsert, 31'd64, 32'h1234_5678);
    send_request(OpInsert, 31'd128, 32'h0000_0001);
    send_request(OpDelete, 31'd0, 32'h0);
    send_request(OpSearch, 31'd0, 32'h0);
    send_request(OpSearch, 31'd64, 32'h0);
    send_request(OpDelete, 31'd64, 32'h0);
    send_request(OpSearch, 31'd128, 32'h0);
    send_request(OpUnknown, 31'd128, 32'h5555_aaaa);
    send_request(OpDelete, 31'd192, 32'h0);
    send_request(OpSearch, 31'h5555_5555, 32'h0);
    send_request(OpDelete, 31'd0, 32'h0);
    send_request(OpSearch, 31'd0, 32'h0);
    drain();

    // Bucket count zero folds to one bucket.
    write_bucket_count(7'd0);
    random_phase(60, 40, 25);
    // Out-of-range count clamps; insert-heavy to exhaust the pool.
    write_bucket_count(7'd127);
    random_phase(330, 88, 4);
    // Change the modulo while entries exist, then drain the pool down.
    write_bucket_count(7'd7);
    random_phase(300, 20, 50);
    write_bucket_count(7'd33);
    random_phase(400, 40, 30);
    write_bucket_count(7'd1);
    random_phase(90, 35, 35);
    write_bucket_count(7'd64);
    random_phase(270, 40, 30);

    $display("Sent %0d requests over six bucket counts; %0d responses checked.",
             n_sent, shadow.n_checked);
    $display("Hits %0d, misses %0d, pool-full inserts %0d.",
             shadow.n_hit, shadow.n_miss, shadow.n_full);
    if (shadow.failures == 0 && shadow.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cht_pkg.sv
rtl/chained_hash_table_engine_unit.sv
dv/tb_chained_hash_table_engine_unit.sv
